/* rtl/nfabm_pkg.sv */
// Package with shared constants, codes and types of the NFA bit-vector matcher.
package nfabm_pkg;

  localparam int NUM_STATES_DEF  = 64;
  localparam int NUM_SYMBOLS_DEF = 16;

  localparam int OP_W    = 3;
  localparam int SYMBOL_W = 4;
  localparam int STATE_W = 6;

  localparam logic [OP_W-1:0] OP_CLEAR     = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD_TRANS = 3'd1;
  localparam logic [OP_W-1:0] OP_SET_INIT  = 3'd2;
  localparam logic [OP_W-1:0] OP_SET_FINAL = 3'd3;
  localparam logic [OP_W-1:0] OP_SAMPLE    = 3'd4;
  localparam logic [OP_W-1:0] OP_EMPTY     = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SWEEP,
    ST_UPDATE
  } ctrl_state_t;

  typedef struct packed {
    logic clear;
    logic read;
    logic write;
    logic set_init;
    logic set_final;
    logic load_init;
    logic update;
  } cell_ctrl_t;

endpackage

/* rtl/nfabm_cell.sv */
// One state cell: successor rows of its state, its flags and one stage of the OR chain.
module nfabm_cell #(
  parameter int NUM_STATES  = nfabm_pkg::NUM_STATES_DEF,
  parameter int NUM_SYMBOLS = nfabm_pkg::NUM_SYMBOLS_DEF,
  localparam int SYM_W      = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  nfabm_pkg::cell_ctrl_t  ctrl,
  input  logic                   sel,
  input  logic [SYM_W-1:0]       idx,
  input  logic                   sym_ok,
  input  logic [NUM_STATES-1:0]  to_mask,
  input  logic [NUM_STATES-1:0]  part_in,
  input  logic                   next_active,
  output logic [NUM_STATES-1:0]  part_out,
  output logic                   init_bit,
  output logic                   final_bit
);

  logic [NUM_STATES-1:0] mem [NUM_SYMBOLS];
  logic [NUM_STATES-1:0] row;
  logic                  active;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      init_bit  <= 1'b0;
      final_bit <= 1'b0;
      active    <= 1'b0;
    end else begin
      if (ctrl.set_init && sel) begin
        init_bit <= 1'b1;
      end
      if (ctrl.set_final && sel) begin
        final_bit <= 1'b1;
      end
      if (ctrl.load_init) begin
        active <= init_bit;
      end else if (ctrl.update) begin
        active <= next_active;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      for (int j = 0; j < NUM_SYMBOLS; j++) begin
        mem[j] <= '0;
      end
    end else if (ctrl.write && sel) begin
      mem[idx] <= row | to_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.read) begin
      row <= sym_ok ? mem[idx] : '0;
    end
  end

  always_ff @(posedge clk) begin
    part_out <= part_in | (active ? row : '0);
  end

endmodule

/* rtl/nfa_bitvector_matcher_core.sv */
// Top level of the NFA bit-vector matcher: command decode, sweep control and the cell chain.
//
//   channel   direction  handshake               payload
//   command   in         start, busy             operation, symbol, from_state, to_state, last
//   result    out        done (one-cycle strobe) matched, alive
//
// Clear, set initial, set final and empty sample act when accepted; add transition reads
// the row, then writes it in ST_WRITE. A sample symbol runs through ST_SWEEP, then ST_UPDATE: the partial
// successor set ripples through one cell per cycle along the chain of state cells.
// Reset and clear zero every row, set and the sample flag.
// The result is shown for one cycle after the last symbol or an empty sample; the
// receiver cannot stall it, and busy is high while a transfer is being worked on.
module nfa_bitvector_matcher_core #(
  parameter int NUM_STATES  = nfabm_pkg::NUM_STATES_DEF,
  parameter int NUM_SYMBOLS = nfabm_pkg::NUM_SYMBOLS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [nfabm_pkg::OP_W-1:0]       operation,
  input  logic [nfabm_pkg::SYMBOL_W-1:0]   symbol,
  input  logic [nfabm_pkg::STATE_W-1:0]    from_state,
  input  logic [nfabm_pkg::STATE_W-1:0]    to_state,
  input  logic                             last,
  output logic                             done,
  output logic                             matched,
  output logic                             alive
);

  localparam int SYM_W   = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int ST_W    = $clog2(NUM_STATES);
  localparam int SYMX_W  = SYM_W + nfabm_pkg::SYMBOL_W;
  localparam int STX_W   = ST_W + nfabm_pkg::STATE_W;
  localparam int STATE_W_L = nfabm_pkg::STATE_W;

  nfabm_pkg::ctrl_state_t state, state_next;
  nfabm_pkg::cell_ctrl_t  ctrl;

  logic                  accept;
  logic                  in_sample;
  logic                  last_q;
  logic                  wr_ok_q;
  logic [SYM_W-1:0]      idx_q;
  logic [STATE_W_L-1:0]  from_q;
  logic [NUM_STATES-1:0] to_mask_q;
  logic [ST_W-1:0]       cnt;

  logic [SYMX_W-1:0]     sym_ext;
  logic [STX_W-1:0]      to_ext;
  logic [STX_W-1:0]      from_ext;
  logic                  sym_ok;
  logic                  to_ok;
  logic                  from_ok;
  logic [NUM_STATES-1:0] to_mask;
  logic [SYM_W-1:0]      cell_idx;
  logic [NUM_STATES-1:0] sel;
  logic [NUM_STATES-1:0] init_vec;
  logic [NUM_STATES-1:0] final_vec;
  logic [NUM_STATES-1:0] part [NUM_STATES];
  logic [NUM_STATES-1:0] tail;

  assign busy   = (state != nfabm_pkg::ST_IDLE);
  assign accept = start && !busy;

  assign sym_ext = {{SYM_W{1'b0}}, symbol};
  assign to_ext  = {{ST_W{1'b0}}, to_state};
  assign from_ext = (state == nfabm_pkg::ST_IDLE) ? {{ST_W{1'b0}}, from_state}
                                                  : {{ST_W{1'b0}}, from_q};
  assign sym_ok  = (sym_ext < SYMX_W'(NUM_SYMBOLS));
  assign to_ok   = (to_ext < STX_W'(NUM_STATES));
  assign from_ok = ({{ST_W{1'b0}}, from_state} < STX_W'(NUM_STATES));
  assign to_mask = to_ok ? (NUM_STATES'(1) << to_ext[ST_W-1:0]) : '0;
  assign cell_idx = (state == nfabm_pkg::ST_IDLE) ? sym_ext[SYM_W-1:0] : idx_q;
  assign tail    = part[NUM_STATES-1];

  always_comb begin
    ctrl = '0;
    if (accept) begin
      unique case (operation)
        nfabm_pkg::OP_CLEAR:     ctrl.clear = 1'b1;
        nfabm_pkg::OP_ADD_TRANS: ctrl.read = 1'b1;
        nfabm_pkg::OP_SET_INIT:  ctrl.set_init = 1'b1;
        nfabm_pkg::OP_SET_FINAL: ctrl.set_final = 1'b1;
        nfabm_pkg::OP_SAMPLE: begin
          ctrl.read      = 1'b1;
          ctrl.load_init = !in_sample;
        end
        nfabm_pkg::OP_EMPTY:     ctrl.load_init = 1'b1;
        default: ;
      endcase
    end
    ctrl.write  = (state == nfabm_pkg::ST_WRITE) && wr_ok_q;
    ctrl.update = (state == nfabm_pkg::ST_UPDATE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nfabm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      nfabm_pkg::ST_IDLE: begin
        if (accept && operation == nfabm_pkg::OP_ADD_TRANS) begin
          state_next = nfabm_pkg::ST_WRITE;
        end else if (accept && operation == nfabm_pkg::OP_SAMPLE) begin
          state_next = nfabm_pkg::ST_SWEEP;
        end
      end
      nfabm_pkg::ST_WRITE:  state_next = nfabm_pkg::ST_IDLE;
      nfabm_pkg::ST_SWEEP: begin
        if (cnt == ST_W'(NUM_STATES - 1)) begin
          state_next = nfabm_pkg::ST_UPDATE;
        end
      end
      nfabm_pkg::ST_UPDATE: state_next = nfabm_pkg::ST_IDLE;
      default:              state_next = nfabm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sample <= 1'b0;
      done      <= 1'b0;
      cnt       <= '0;
    end else begin
      done <= (accept && operation == nfabm_pkg::OP_EMPTY) ||
              (state == nfabm_pkg::ST_UPDATE && last_q);
      if (state == nfabm_pkg::ST_SWEEP) begin
        cnt <= cnt + ST_W'(1);
      end else begin
        cnt <= '0;
      end
      if (accept) begin
        case (operation)
          nfabm_pkg::OP_CLEAR:  in_sample <= 1'b0;
          nfabm_pkg::OP_SAMPLE: in_sample <= !last;
          nfabm_pkg::OP_EMPTY:  in_sample <= 1'b0;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_q    <= last;
      idx_q     <= sym_ext[SYM_W-1:0];
      from_q    <= from_state;
      to_mask_q <= to_mask;
      wr_ok_q   <= sym_ok && to_ok && from_ok;
      if (operation == nfabm_pkg::OP_EMPTY) begin
        matched <= |(init_vec & final_vec);
        alive   <= |init_vec;
      end
    end
    if (state == nfabm_pkg::ST_UPDATE) begin
      matched <= |(tail & final_vec);
      alive   <= |tail;
    end
  end

  for (genvar i = 0; i < NUM_STATES; i++) begin : g_cell
    assign sel[i] = (from_ext == STX_W'(i));

    if (i == 0) begin : g_head
      nfabm_cell #(
        .NUM_STATES  (NUM_STATES),
        .NUM_SYMBOLS (NUM_SYMBOLS)
      ) u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctrl        (ctrl),
        .sel         (sel[i]),
        .idx         (cell_idx),
        .sym_ok      (sym_ok),
        .to_mask     (to_mask_q),
        .part_in     ({NUM_STATES{1'b0}}),
        .next_active (tail[i]),
        .part_out    (part[i]),
        .init_bit    (init_vec[i]),
        .final_bit   (final_vec[i])
      );
    end else begin : g_body
      nfabm_cell #(
        .NUM_STATES  (NUM_STATES),
        .NUM_SYMBOLS (NUM_SYMBOLS)
      ) u_cell (
        .clk         (clk),
        .rst         (rst),
        .ctrl        (ctrl),
        .sel         (sel[i]),
        .idx         (cell_idx),
        .sym_ok      (sym_ok),
        .to_mask     (to_mask_q),
        .part_in     (part[i-1]),
        .next_active (tail[i]),
        .part_out    (part[i]),
        .init_bit    (init_vec[i]),
        .final_bit   (final_vec[i])
      );
    end
  end

endmodule

/* tb/tb.sv */
// Self-checking testbench for the NFA bit-vector matcher core with a built-in state-set predictor.
module tb;
  import nfabm_pkg::*;

  localparam int NS = NUM_STATES_DEF;
  localparam int NSYM = NUM_SYMBOLS_DEF;
  localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES = NS + 16;
  localparam int ITEMS_PER_PHASE = 330;

  typedef struct packed {
    logic matched;
    logic alive;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [OP_W-1:0] operation = '0;
  logic [SYMBOL_W-1:0] symbol = '0;
  logic [STATE_W-1:0] from_state = '0;
  logic [STATE_W-1:0] to_state = '0;
  logic last = 1'b0;
  logic done;
  logic matched;
  logic alive;

  logic [NS-1:0] succ_rows [NS*NSYM];
  logic [NS-1:0] init_states;
  logic [NS-1:0] final_states;
  logic [NS-1:0] live_states;
  logic sample_open;
  verdict_t expected_verdicts[$];
  verdict_t got;
  int errors = 0;
  int cmd_count = 0;
  int sender_idle_pct = 0;
  int stall_cycles = 0;

  nfa_bitvector_matcher_core dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .symbol(symbol),
    .from_state(from_state),
    .to_state(to_state),
    .last(last),
    .done(done),
    .matched(matched),
    .alive(alive)
  );

  always #2 clk = ~clk;

  function automatic logic [OP_W-1:0] rnd_op();
    return OP_W'($urandom_range(7));
  endfunction

  function automatic logic [SYMBOL_W-1:0] rnd_sym();
    return SYMBOL_W'($urandom_range(15));
  endfunction

  function automatic logic [STATE_W-1:0] rnd_state();
    return STATE_W'($urandom_range(63));
  endfunction

  function automatic logic rnd_bit();
    return ($urandom_range(1) != 0);
  endfunction

  function automatic void clear_automaton();
    for (int i = 0; i < NS*NSYM; i++) succ_rows[i] = '0;
    init_states = '0;
    final_states = '0;
    live_states = '0;
    sample_open = 1'b0;
  endfunction

  function automatic logic [NS-1:0] follow_symbol(logic [NS-1:0] cur, int unsigned sym);
    logic [NS-1:0] nxt;
    nxt = '0;
    if (sym < NSYM) begin
      for (int s = 0; s < NS; s++) begin
        if (cur[s]) nxt |= succ_rows[s*NSYM + sym];
      end
    end
    return nxt;
  endfunction

  function automatic void predict_cmd(logic [OP_W-1:0] op, logic [SYMBOL_W-1:0] sym,
                                      logic [STATE_W-1:0] src, logic [STATE_W-1:0] dst,
                                      logic lst);
    verdict_t v;
    logic report;
    report = 1'b0;
    case (op)
      OP_CLEAR: clear_automaton();
      OP_ADD_TRANS: begin
        if (int'(src) < NS && int'(dst) < NS && int'(sym) < NSYM)
          succ_rows[int'(src)*NSYM + int'(sym)][dst] = 1'b1;
      end
      OP_SET_INIT: begin
        if (int'(src) < NS) init_states[src] = 1'b1;
      end
      OP_SET_FINAL: begin
        if (int'(src) < NS) final_states[src] = 1'b1;
      end
      OP_SAMPLE: begin
        if (!sample_open) begin
          live_states = init_states;
          sample_open = 1'b1;
        end
        live_states = follow_symbol(live_states, sym);
        if (lst) begin
          sample_open = 1'b0;
          report = 1'b1;
        end
      end
      OP_EMPTY: begin
        live_states = init_states;
        sample_open = 1'b0;
        report = 1'b1;
      end
      default: ;
    endcase
    if (report) begin
      v.matched = |(live_states & final_states);
      v.alive = |live_states;
      expected_verdicts.push_back(v);
    end
  endfunction

  task automatic pause_cycle();
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_cmd(logic [OP_W-1:0] op, logic [SYMBOL_W-1:0] sym,
                          logic [STATE_W-1:0] src, logic [STATE_W-1:0] dst, logic lst);
    while ($urandom_range(99) < sender_idle_pct) pause_cycle();
    start <= 1'b1;
    operation <= op;
    symbol <= sym;
    from_state <= src;
    to_state <= dst;
    last <= lst;
    do @(posedge clk); while (busy);
    predict_cmd(op, sym, src, dst, lst);
    if (op <= OP_EMPTY) cmd_count++;
  endtask

  task automatic drain_results();
    while (expected_verdicts.size() != 0) pause_cycle();
  endtask

  task automatic test_directed_cases();
    sender_idle_pct = 0;
    send_cmd(OP_CLEAR, 0, 0, 0, 0);
    send_cmd(OP_EMPTY, 0, 0, 0, 0);
    send_cmd(OP_SAMPLE, 0, 0, 0, 1);
    send_cmd(OP_SET_INIT, 0, 0, 0, 0);
    send_cmd(OP_SET_INIT, 0, 63, 0, 0);
    send_cmd(OP_SET_FINAL, 0, 63, 0, 0);
    send_cmd(OP_EMPTY, 15, 63, 63, 1);
    send_cmd(OP_ADD_TRANS, 15, 0, 63, 0);
    send_cmd(OP_ADD_TRANS, 0, 63, 0, 0);
    send_cmd(OP_ADD_TRANS, 15, 63, 63, 1);
    send_cmd(OP_ADD_TRANS, 10, 42, 21, 0);
    send_cmd(OP_SAMPLE, 15, 0, 0, 0);
    send_cmd(OP_SET_FINAL, 0, 0, 0, 0);
    send_cmd(OP_SAMPLE, 0, 0, 0, 1);
    send_cmd(OP_SAMPLE, 5, 0, 0, 1);
    send_cmd(OP_SAMPLE, 15, 0, 0, 0);
    send_cmd(OP_EMPTY, 0, 0, 0, 0);
    send_cmd(OP_SAMPLE, 3, 0, 0, 0);
    send_cmd(OP_SAMPLE, 0, 0, 0, 1);
    send_cmd(OP_SAMPLE, 0, 0, 0, 0);
    send_cmd(OP_RSVD_6, 15, 63, 63, 1);
    send_cmd(OP_RSVD_7, 15, 63, 63, 1);
    send_cmd(OP_CLEAR, 15, 63, 63, 1);
    send_cmd(OP_SAMPLE, 0, 0, 0, 1);
  endtask

  task automatic test_random_automata(int idle_pct, int n_items);
    int stop_at;
    int k;
    int asz;
    int base;
    int len;
    logic need_build;
    logic [STATE_W-1:0] pool [10];
    sender_idle_pct = idle_pct;
    stop_at = cmd_count + n_items;
    need_build = 1'b1;
    k = 1;
    asz = 1;
    base = 0;
    while (cmd_count < stop_at) begin
      if (need_build || $urandom_range(99) < 8) begin
        need_build = 1'b0;
        if ($urandom_range(3) != 0)
          send_cmd(OP_CLEAR, rnd_sym(), rnd_state(), rnd_state(), rnd_bit());
        k = $urandom_range(3, 10);
        for (int i = 0; i < k; i++) pool[i] = rnd_state();
        asz = $urandom_range(1, 4);
        base = $urandom_range(0, NSYM - asz);
        repeat ($urandom_range(k, 3*k))
          send_cmd(OP_ADD_TRANS, SYMBOL_W'(base + $urandom_range(asz - 1)),
                   pool[$urandom_range(k - 1)], pool[$urandom_range(k - 1)], rnd_bit());
        repeat ($urandom_range(1, 2))
          send_cmd(OP_SET_INIT, rnd_sym(), pool[$urandom_range(k - 1)], rnd_state(),
                   rnd_bit());
        repeat ($urandom_range(1, 3))
          send_cmd(OP_SET_FINAL, rnd_sym(), pool[$urandom_range(k - 1)], rnd_state(),
                   rnd_bit());
      end else if ($urandom_range(99) < 6) begin
        send_cmd(OP_EMPTY, rnd_sym(), rnd_state(), rnd_state(), rnd_bit());
      end else if ($urandom_range(99) < 6) begin
        send_cmd(rnd_op(), rnd_sym(), rnd_state(), rnd_state(), rnd_bit());
      end else begin
        len = $urandom_range(1, 6);
        for (int i = 1; i <= len; i++) begin
          if ($urandom_range(99) < 4)
            send_cmd(rnd_op(), rnd_sym(), pool[$urandom_range(k - 1)],
                     pool[$urandom_range(k - 1)], rnd_bit());
          send_cmd(OP_SAMPLE,
                   ($urandom_range(9) == 0) ? rnd_sym()
                                            : SYMBOL_W'(base + $urandom_range(asz - 1)),
                   rnd_state(), rnd_state(), i == len);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_verdicts.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual matched=%0b alive=%0b",
                 $time, matched, alive);
      end else begin
        got = expected_verdicts.pop_front();
        if (got.matched !== matched) begin
          errors++;
          $display("%0t: matched mismatch, expected %0b, actual %0b", $time, got.matched,
                   matched);
        end
        if (got.alive !== alive) begin
          errors++;
          $display("%0t: alive mismatch, expected %0b, actual %0b", $time, got.alive, alive);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, stall_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    clear_automaton();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    drain_results();
    test_random_automata(0, ITEMS_PER_PHASE);
    test_random_automata(83, ITEMS_PER_PHASE);
    drain_results();
    test_random_automata(0, ITEMS_PER_PHASE);
    test_random_automata(37, ITEMS_PER_PHASE);
    drain_results();
    start <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
